// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame segmenter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define TFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond must never be true outside reset
`define TFS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame segmenter package
// Sizes, codes and control bundles shared by the segmenter modules.
// ----------------------------------------------------------------------------
package tfs_pkg;

   localparam int FRAME_BYTES = 128;
   localparam int FRAME_WORDS = FRAME_BYTES / 2;
   localparam int ADDR_W      = $clog2(FRAME_WORDS);
   localparam int FILL_W      = $clog2(FRAME_WORDS + 1);
   localparam int WORD_W      = 16;
   localparam int OPC_W       = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [OPC_W-1:0] {
      OP_ADD         = 3'd0,
      OP_START       = 3'd1,
      OP_STOP        = 3'd2,
      OP_FINISH      = 3'd3,
      OP_SINGLE_OPEN = 3'd4,
      OP_SINGLE_WORD = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      REG_TYPE_SINGLE = 3'd0,
      REG_TYPE_START  = 3'd1,
      REG_TYPE_CONT   = 3'd2,
      REG_TYPE_STOP   = 3'd3,
      REG_PAD_WORD    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_SEND,
      S_OPEN_HDR,
      S_OPEN_NUM,
      S_PUT_SESSION,
      S_PUT_DATA,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_PAD,
      WR_HDR,
      WR_NUM,
      WR_SESSION,
      WR_DATA
   } wr_sel_type;

   typedef enum logic [1:0] {
      HDR_SINGLE,
      HDR_START,
      HDR_CONT,
      HDR_STOP
   } hdr_sel_type;

   typedef struct packed {
      wr_sel_type  wr_sel;
      hdr_sel_type hdr_sel;
      logic        data_load;
      logic        num_inc;
      logic        send;
      logic        send_end;
      logic        single_set;
      logic        single_clr;
      logic        session_load;
      logic        finish_clr;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic fill_full;
      logic single_active;
      logic send_done;
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] type_single;
      logic [WORD_W-1:0] type_start;
      logic [WORD_W-1:0] type_cont;
      logic [WORD_W-1:0] type_stop;
      logic [WORD_W-1:0] pad_word;
   } cfg_type;

endpackage

// File: sv/tfs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one segmenter command per transfer.
// ----------------------------------------------------------------------------
interface tfs_req_if;
   import tfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [OPC_W-1:0]  opcode;
   logic [WORD_W-1:0] data_word;
   logic              last;

   modport source (output valid, output opcode, output data_word, output last,
                   input ready);
   modport sink (input valid, input opcode, input data_word, input last,
                 output ready);
endinterface

// File: sv/tfs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one frame word per transfer.
// ----------------------------------------------------------------------------
interface tfs_rsp_if;
   import tfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] frame_word;
   logic              last_word;

   modport source (output valid, output frame_word, output last_word,
                   input ready);
   modport sink (input valid, input frame_word, input last_word,
                 output ready);
endinterface

// File: sv/tfs_csr.sv
// ----------------------------------------------------------------------------
// Segmenter register file
// APB-style access to the header type words and the pad word.
// ----------------------------------------------------------------------------
module tfs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output tfs_pkg::cfg_type               cfg
);
   import tfs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;
   logic [WORD_W-1:0] rd_word;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_TYPE_SINGLE: cfg_in.type_single = csr_pwdata[WORD_W-1:0];
            REG_TYPE_START:  cfg_in.type_start  = csr_pwdata[WORD_W-1:0];
            REG_TYPE_CONT:   cfg_in.type_cont   = csr_pwdata[WORD_W-1:0];
            REG_TYPE_STOP:   cfg_in.type_stop   = csr_pwdata[WORD_W-1:0];
            REG_PAD_WORD:    cfg_in.pad_word    = csr_pwdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TYPE_SINGLE: rd_word = cfg_ff.type_single;
         REG_TYPE_START:  rd_word = cfg_ff.type_start;
         REG_TYPE_CONT:   rd_word = cfg_ff.type_cont;
         REG_TYPE_STOP:   rd_word = cfg_ff.type_stop;
         REG_PAD_WORD:    rd_word = cfg_ff.pad_word;
         default:         rd_word = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: sv/tfs_ctrl.sv
// ----------------------------------------------------------------------------
// Segmenter controller
// Sequences pad, send, frame open and word append steps for each command.
// ----------------------------------------------------------------------------
module tfs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [tfs_pkg::OPC_W-1:0] req_opcode,
   input  logic                      req_last,
   input  tfs_pkg::status_type       status,
   output tfs_pkg::cmd_type          cmd
);
   import tfs_pkg::*;

   state_type  state_ff, state_in;
   opcode_type op_ff, op_in;
   logic       last_ff, last_in;
   opcode_type req_op;
   logic       accept;

   assign req_op    = opcode_type'(req_opcode);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_ready && req_valid;
   assign op_in     = accept ? req_op : op_ff;
   assign last_in   = accept ? req_last : last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op) inside
                  OP_ADD: begin
                     if (status.fill_full)       state_in = S_SEND;
                     else if (!status.fill_zero) state_in = S_PUT_DATA;
                  end
                  OP_START, OP_STOP: begin
                     state_in = status.fill_zero ? S_OPEN_HDR : S_PAD;
                  end
                  OP_FINISH: begin
                     state_in = status.fill_zero ? S_FINISH : S_PAD;
                  end
                  OP_SINGLE_OPEN: state_in = S_OPEN_HDR;
                  OP_SINGLE_WORD: begin
                     if (status.single_active) state_in = S_PUT_DATA;
                  end
                  default: ;
               endcase
            end
         end
         S_PAD: begin
            if (status.fill_full) state_in = S_SEND;
         end
         S_SEND: begin
            if (status.send_done) begin
               unique case (op_ff) inside
                  OP_ADD, OP_START, OP_STOP: state_in = S_OPEN_HDR;
                  OP_FINISH:                 state_in = S_FINISH;
                  default:                   state_in = S_IDLE;
               endcase
            end
         end
         S_OPEN_HDR: state_in = S_OPEN_NUM;
         S_OPEN_NUM: begin
            unique case (op_ff)
               OP_ADD:         state_in = S_PUT_SESSION;
               OP_START:       state_in = S_PUT_DATA;
               OP_SINGLE_OPEN: state_in = last_ff ? S_PAD : S_IDLE;
               default:        state_in = S_IDLE;
            endcase
         end
         S_PUT_SESSION: state_in = S_PUT_DATA;
         S_PUT_DATA: begin
            if (op_ff == OP_SINGLE_WORD && last_ff) state_in = S_PAD;
            else                                    state_in = S_IDLE;
         end
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.wr_sel  = WR_NONE;
      cmd.hdr_sel = HDR_SINGLE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.data_load = 1'b1;
               unique case (req_op) inside
                  OP_ADD, OP_START, OP_STOP, OP_FINISH: cmd.single_clr = 1'b1;
                  OP_SINGLE_OPEN: begin
                     cmd.single_set = !req_last;
                     cmd.single_clr = req_last;
                  end
                  OP_SINGLE_WORD: cmd.single_clr = req_last;
                  default: ;
               endcase
            end
         end
         S_PAD: cmd.wr_sel = WR_PAD;
         S_SEND: begin
            cmd.send     = 1'b1;
            cmd.send_end = status.send_done;
         end
         S_OPEN_HDR: begin
            cmd.wr_sel = WR_HDR;
            unique case (op_ff)
               OP_ADD:   cmd.hdr_sel = HDR_CONT;
               OP_START: cmd.hdr_sel = HDR_START;
               OP_STOP:  cmd.hdr_sel = HDR_STOP;
               default:  cmd.hdr_sel = HDR_SINGLE;
            endcase
         end
         S_OPEN_NUM: begin
            cmd.wr_sel  = WR_NUM;
            cmd.num_inc = 1'b1;
         end
         S_PUT_SESSION: cmd.wr_sel = WR_SESSION;
         S_PUT_DATA: begin
            cmd.wr_sel       = WR_DATA;
            cmd.session_load = (op_ff == OP_START);
         end
         S_FINISH: cmd.finish_clr = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ADD;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         last_ff  <= last_in;
      end
   end
endmodule

// File: sv/tfs_dp.sv
// ----------------------------------------------------------------------------
// Segmenter datapath
// Frame buffer, fill and read pointers, frame number, session type and
// the registered output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfs_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  tfs_pkg::cmd_type           cmd,
   output tfs_pkg::status_type        status,
   input  tfs_pkg::cfg_type           cfg,
   input  logic [tfs_pkg::WORD_W-1:0] req_data_word,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [tfs_pkg::WORD_W-1:0] rsp_frame_word,
   output logic                       rsp_last_word
);
   import tfs_pkg::*;

   logic [WORD_W-1:0] mem [FRAME_WORDS];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [WORD_W-1:0] number_ff, number_in;
   logic [WORD_W-1:0] session_ff, session_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              single_ff, single_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rsp_last_ff;

   logic              full;
   logic              send_done;
   logic              rd_issue;
   logic              last_issue;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_word;
   logic [WORD_W-1:0] hdr_word;

   assign full       = (fill_ff == FILL_W'(FRAME_WORDS));
   assign send_done  = (rd_ptr_ff == FILL_W'(FRAME_WORDS));
   assign rd_issue   = cmd.send && !send_done && (!rsp_valid_ff || rsp_ready);
   assign last_issue = rd_issue && (rd_ptr_ff == FILL_W'(FRAME_WORDS - 1));

   always_comb begin
      unique case (cmd.hdr_sel)
         HDR_SINGLE: hdr_word = cfg.type_single;
         HDR_START:  hdr_word = cfg.type_start;
         HDR_CONT:   hdr_word = cfg.type_cont;
         HDR_STOP:   hdr_word = cfg.type_stop;
         default:    hdr_word = cfg.type_single;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_PAD:     wr_word = cfg.pad_word;
         WR_HDR:     wr_word = hdr_word;
         WR_NUM:     wr_word = number_ff;
         WR_SESSION: wr_word = session_ff;
         WR_DATA:    wr_word = data_ff;
         default:    wr_word = data_ff;
      endcase
   end

   // a header write reopens the frame at entry zero
   assign wr_en   = (cmd.wr_sel == WR_HDR) || ((cmd.wr_sel != WR_NONE) && !full);
   assign wr_addr = (cmd.wr_sel == WR_HDR) ? '0 : fill_ff[ADDR_W-1:0];

   always_comb begin
      fill_in = fill_ff;
      if (cmd.send_end)               fill_in = '0;
      else if (cmd.wr_sel == WR_HDR)  fill_in = FILL_W'(1);
      else if (wr_en)                 fill_in = fill_ff + FILL_W'(1);
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.send_end)  rd_ptr_in = '0;
      else if (rd_issue) rd_ptr_in = rd_ptr_ff + FILL_W'(1);
   end

   always_comb begin
      number_in = number_ff;
      if (cmd.finish_clr)   number_in = '0;
      else if (cmd.num_inc) number_in = number_ff + WORD_W'(1);
   end

   always_comb begin
      session_in = session_ff;
      if (cmd.finish_clr)        session_in = cfg.pad_word;
      else if (cmd.session_load) session_in = data_ff;
   end

   always_comb begin
      single_in = single_ff;
      if (cmd.single_clr)      single_in = 1'b0;
      else if (cmd.single_set) single_in = 1'b1;
   end

   assign data_in      = cmd.data_load ? req_data_word : data_ff;
   assign rsp_valid_in = rd_issue ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rd_ptr_ff    <= '0;
         number_ff    <= '0;
         session_ff   <= '0;
         single_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rd_ptr_ff    <= rd_ptr_in;
         number_ff    <= number_in;
         session_ff   <= session_in;
         single_ff    <= single_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // frame buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff  <= mem[rd_ptr_ff[ADDR_W-1:0]];
         rsp_last_ff <= (rd_ptr_ff == FILL_W'(FRAME_WORDS - 1));
      end
   end

   assign status.fill_zero     = (fill_ff == '0);
   assign status.fill_full     = full;
   assign status.single_active = single_ff;
   assign status.send_done     = send_done;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_word = rd_data_ff;
   assign rsp_last_word  = rsp_last_ff;

   `TFS_ASSERT_NEVER(a_fill_bound, clock, reset, fill_ff > FILL_W'(FRAME_WORDS), "fill overflow")
   `TFS_ASSERT(a_send_full, clock, reset, cmd.send |-> full, "send of unpadded frame")
   `TFS_ASSERT(a_last_word, clock, reset, last_issue |=> rsp_last_ff, "final word not flagged")
endmodule

// File: sv/telemetry_frame_segmenter.sv
// ----------------------------------------------------------------------------
// Telemetry frame segmenter
// Packs 16-bit telemetry words into fixed frames and streams them out.
// ----------------------------------------------------------------------------
// One command is taken at a time; req ready drops until its steps are done.
// An add or single word is its transfer plus one buffer write; a start or
// stop on an empty buffer writes the header and number words, and a start
// its data word. Sending a frame first pads the open frame, one buffer
// write per cycle, then reads the frame buffer through its registered read
// port one word per cycle while the response side does not stall, then for
// an add, start or stop writes the next frame's header words. The output
// word register lets the next command be taken while the final frame word
// still waits for its transfer. No clearing pass.
module telemetry_frame_segmenter (
   input  logic                           clock,
   input  logic                           reset,
   tfs_req_if.sink                        req_ch,
   tfs_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tfs_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   tfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_opcode (req_ch.opcode),
      .req_last   (req_ch.last),
      .status     (status),
      .cmd        (cmd)
   );

   tfs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg),
      .req_data_word  (req_ch.data_word),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_frame_word (rsp_ch.frame_word),
      .rsp_last_word  (rsp_ch.last_word)
   );
endmodule
